// ===== sv/svd_pkg.sv =====
// Shared widths, register indexes and the result beat type for the
// delta stream variable-byte decoder. No dependencies.
package svd_pkg;

   localparam int DEFAULT_MAX_VALUES = 1024;
   localparam int BYTE_W             = 8;
   localparam int VALUE_W            = 32;
   localparam int COUNT_W            = 11;
   localparam int TOTAL_W            = 13;
   localparam int ASM_W              = 24;
   localparam int CODE_W             = 2;
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VALUE_COUNT = 1'b0,
      CSR_START_VALUE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic [TOTAL_W-1:0] bytes;
   } result_type;

endpackage

// ===== sv/svd_key_store.sv =====
// Control byte store: one write port, one registered read port with
// write-first bypass. Depends on svd_pkg.
module svd_key_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [svd_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [svd_pkg::BYTE_W-1:0] rd_data
);
   import svd_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/svd_datapath.sv =====
// Decode state: control byte collection, little endian delta assembly and the
// running sum. Depends on svd_pkg; drives the svd_key_store ports.
module svd_datapath #(
   parameter int MAX_VALUES = svd_pkg::DEFAULT_MAX_VALUES,
   parameter int KEY_DEPTH  = (MAX_VALUES + 3) / 4,
   parameter int ADDR_W     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [svd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            accept,
   input  logic [svd_pkg::BYTE_W-1:0]      in_byte,
   input  logic [svd_pkg::BYTE_W-1:0]      key_rd_data,
   output logic                            key_wr_en,
   output logic [ADDR_W-1:0]               key_wr_addr,
   output logic [svd_pkg::BYTE_W-1:0]      key_wr_data,
   output logic [ADDR_W-1:0]               key_rd_addr,
   output svd_pkg::result_type             result
);
   import svd_pkg::*;

   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int KEY_W = $clog2(KEY_DEPTH + 1);

   logic                phase_ff, phase_in;
   logic [KEY_W-1:0]    seen_ff, seen_in;
   logic [CNT_W-1:0]    done_ff, done_in;
   logic [1:0]          bov_ff, bov_in;
   logic [ASM_W-1:0]    asm_ff, asm_in;
   logic [VALUE_W-1:0]  sum_ff, sum_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [KEY_W-1:0]    key_len_ff, key_len_in;
   logic [VALUE_W-1:0]  start_ff, start_in;

   logic [CODE_W-1:0]   code;
   logic [VALUE_W-1:0]  delta;
   logic [VALUE_W-1:0]  new_sum;
   logic [CNT_W-1:0]    done_next;
   logic [KEY_W-1:0]    seen_next;
   logic [TOTAL_W-1:0]  total_next;
   logic                is_last;
   logic [CNT_W:0]      cnt_plus;

   always_comb begin
      case (done_ff[1:0])
         2'd0:    code = key_rd_data[1:0];
         2'd1:    code = key_rd_data[3:2];
         2'd2:    code = key_rd_data[5:4];
         2'd3:    code = key_rd_data[7:6];
         default: code = key_rd_data[1:0];
      endcase
   end

   assign delta      = VALUE_W'(asm_ff) | (VALUE_W'(in_byte) << {bov_ff, 3'b000});
   assign new_sum    = sum_ff + delta;
   assign done_next  = done_ff + 1'b1;
   assign seen_next  = seen_ff + 1'b1;
   assign total_next = total_ff + 1'b1;
   assign is_last    = (done_next >= cnt_ff);

   always_comb begin
      phase_in   = phase_ff;
      seen_in    = seen_ff;
      done_in    = done_ff;
      bov_in     = bov_ff;
      asm_in     = asm_ff;
      sum_in     = sum_ff;
      total_in   = total_ff;
      cnt_in     = cnt_ff;
      key_len_in = key_len_ff;
      start_in   = start_ff;
      cnt_plus   = '0;
      key_wr_en  = 1'b0;
      result     = '0;

      if (csr_write) begin
         if (csr_index == CSR_VALUE_COUNT) begin
            if (32'(csr_wdata[COUNT_W-1:0]) > 32'(MAX_VALUES)) begin
               cnt_in = CNT_W'(MAX_VALUES);
            end else begin
               cnt_in = CNT_W'(csr_wdata[COUNT_W-1:0]);
            end
            cnt_plus   = (CNT_W+1)'(cnt_in) + (CNT_W+1)'(3);
            key_len_in = KEY_W'(cnt_plus >> 2);
         end else begin
            start_in = csr_wdata[VALUE_W-1:0];
         end
         phase_in = 1'b0;
         seen_in  = '0;
         done_in  = '0;
         bov_in   = '0;
         asm_in   = '0;
         total_in = '0;
         sum_in   = start_in;
      end else if (accept && (cnt_ff != '0)) begin
         total_in = total_next;
         if (!phase_ff) begin
            key_wr_en = 1'b1;
            seen_in   = seen_next;
            if (seen_next >= key_len_ff) begin
               phase_in = 1'b1;
            end
         end else if (bov_ff < code) begin
            asm_in = asm_ff | (ASM_W'(in_byte) << {bov_ff, 3'b000});
            bov_in = bov_ff + 1'b1;
         end else begin
            result.valid = 1'b1;
            result.value = new_sum;
            result.last  = is_last;
            result.bytes = is_last ? total_next : '0;
            bov_in       = '0;
            asm_in       = '0;
            if (is_last) begin
               phase_in = 1'b0;
               seen_in  = '0;
               done_in  = '0;
               total_in = '0;
               sum_in   = start_ff;
            end else begin
               done_in = done_next;
               sum_in  = new_sum;
            end
         end
      end
   end

   assign key_wr_addr = seen_ff[ADDR_W-1:0];
   assign key_wr_data = in_byte;
   assign key_rd_addr = done_in[ADDR_W+1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         seen_ff    <= '0;
         done_ff    <= '0;
         bov_ff     <= '0;
         asm_ff     <= '0;
         sum_ff     <= '0;
         total_ff   <= '0;
         cnt_ff     <= '0;
         key_len_ff <= '0;
         start_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         seen_ff    <= seen_in;
         done_ff    <= done_in;
         bov_ff     <= bov_in;
         asm_ff     <= asm_in;
         sum_ff     <= sum_in;
         total_ff   <= total_in;
         cnt_ff     <= cnt_in;
         key_len_ff <= key_len_in;
         start_ff   <= start_in;
      end
   end

   a_phase_keys_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (seen_ff == key_len_ff))
      else $error("data phase entered before all control bytes were stored");

   a_collect_no_values: assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> (done_ff == '0) && (bov_ff == '0))
      else $error("value progress while collecting control bytes");

   a_done_below_count: assert property (@(posedge clock) disable iff (reset)
      (done_ff == '0) || (done_ff < cnt_ff))
      else $error("value counter reached the count without rearming");

   a_result_in_data: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> phase_ff && !csr_write)
      else $error("result beat outside the data phase");

endmodule

// ===== sv/svd_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
// Depends on svd_pkg.
module svd_out_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  svd_pkg::result_type             result,
   input  logic                            rsp_stall,
   output logic                            full_stalled,
   output logic                            rsp_valid,
   output logic [svd_pkg::VALUE_W-1:0]     rsp_decoded_value,
   output logic                            rsp_last_value,
   output logic [svd_pkg::TOTAL_W-1:0]     rsp_bytes_used
);
   import svd_pkg::*;

   logic               valid_ff, valid_in;
   logic [VALUE_W-1:0] value_ff;
   logic               last_ff;
   logic [TOTAL_W-1:0] bytes_ff;
   logic               load;

   assign full_stalled = valid_ff && rsp_stall;
   assign load         = result.valid && !full_stalled;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= result.value;
         last_ff  <= result.last;
         bytes_ff <= result.bytes;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_decoded_value = value_ff;
   assign rsp_last_value    = last_ff;
   assign rsp_bytes_used    = bytes_ff;

endmodule

// ===== sv/stream_vbyte_delta_decoder.sv =====
// Delta stream variable-byte decoder, 32-bit values: top level.
// Depends on svd_pkg, svd_key_store, svd_datapath and svd_out_reg.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | req_in_byte
//   rsp_    | out       | rsp_valid / rsp_stall  | rsp_decoded_value, rsp_last_value,
//           |           |                        | rsp_bytes_used
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One buffer byte per cycle while req_stall is low; a byte that completes a value shows
// on rsp_ in the cycle after it is accepted.
// The control byte for the next value is read from the key store in the cycle
// before it is needed, through its registered read port.
// Synchronous reset clears all control state; the key store is not cleared.
// req_stall is high only while a result beat is held by rsp_stall.
module stream_vbyte_delta_decoder #(
   parameter int MAX_VALUES = svd_pkg::DEFAULT_MAX_VALUES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [svd_pkg::BYTE_W-1:0]      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [svd_pkg::VALUE_W-1:0]     rsp_decoded_value,
   output logic                            rsp_last_value,
   output logic [svd_pkg::TOTAL_W-1:0]     rsp_bytes_used,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [svd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import svd_pkg::*;

   localparam int KEY_DEPTH = (MAX_VALUES + 3) / 4;
   localparam int ADDR_W    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   logic              accept;
   logic              csr_write;
   logic              full_stalled;
   logic              key_wr_en;
   logic [ADDR_W-1:0] key_wr_addr;
   logic [BYTE_W-1:0] key_wr_data;
   logic [ADDR_W-1:0] key_rd_addr;
   logic [BYTE_W-1:0] key_rd_data;
   result_type        result;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_stall = full_stalled;
   assign accept    = req_valid && !req_stall;

   svd_key_store #(
      .DEPTH  (KEY_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   svd_datapath #(
      .MAX_VALUES (MAX_VALUES),
      .KEY_DEPTH  (KEY_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .key_rd_data (key_rd_data),
      .key_wr_en   (key_wr_en),
      .key_wr_addr (key_wr_addr),
      .key_wr_data (key_wr_data),
      .key_rd_addr (key_rd_addr),
      .result      (result)
   );

   svd_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .rsp_stall         (rsp_stall),
      .full_stalled      (full_stalled),
      .rsp_valid         (rsp_valid),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last_value    (rsp_last_value),
      .rsp_bytes_used    (rsp_bytes_used)
   );

endmodule

// ===== tb/tb_stream_vbyte_delta_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stream_vbyte_delta_decoder: random-gap byte driver,
// stalling result monitor and a running-sum predictor of the decoder.
// Depends on svd_pkg and the decoder RTL.
module tb_stream_vbyte_delta_decoder;
   import svd_pkg::*;

   localparam int MAX_VALUES  = DEFAULT_MAX_VALUES;
   localparam int KEY_DEPTH   = (MAX_VALUES + 3) / 4;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL        = 8;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_BYTES = 140;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
      logic [TOTAL_W-1:0] bytes;
   } sum_beat_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_in_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [VALUE_W-1:0]     rsp_decoded_value;
   logic                   rsp_last_value;
   logic [TOTAL_W-1:0]     rsp_bytes_used;
   logic                   csr_valid;
   logic                   csr_ready;
   csr_index_type          csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   stream_vbyte_delta_decoder #(.MAX_VALUES(MAX_VALUES)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last_value    (rsp_last_value),
      .rsp_bytes_used    (rsp_bytes_used),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // decoder shadow state
   logic [BYTE_W-1:0]  key_bytes [KEY_DEPTH];
   logic [COUNT_W-1:0] cfg_count = '0;
   logic [VALUE_W-1:0] cfg_start = '0;
   logic               in_data = 1'b0;
   int unsigned        keys_seen = 0;
   int unsigned        values_out = 0;
   int unsigned        byte_pos = 0;
   logic [VALUE_W-1:0] partial = '0;
   logic [VALUE_W-1:0] sum = '0;
   int unsigned        consumed = 0;

   sum_beat_type       pending_sums [$];
   logic [BYTE_W-1:0]  byte_queue [$];
   sum_beat_type       want;

   int unsigned bytes_pushed = 0;
   int unsigned bytes_taken = 0;
   int unsigned values_checked = 0;
   int unsigned buffers_done = 0;
   int unsigned errors = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned cycles = 0;
   int          src_gap = 0;
   int          stall_left = 0;
   bit          src_steady = 1'b0;
   bit          rsp_steady = 1'b0;

   function automatic void restart_buffer();
      in_data    = 1'b0;
      keys_seen  = 0;
      values_out = 0;
      byte_pos   = 0;
      partial    = '0;
      consumed   = 0;
      sum        = cfg_start;
   endfunction

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      int unsigned        n_eff;
      int unsigned        code;
      logic [VALUE_W-1:0] delta;
      sum_beat_type       beat;
      n_eff = (32'(cfg_count) > MAX_VALUES) ? MAX_VALUES : 32'(cfg_count);
      if (n_eff == 0) return;
      if (!in_data) begin
         key_bytes[keys_seen] = b;
         keys_seen++;
         consumed++;
         if (keys_seen >= (n_eff + 3) / 4) in_data = 1'b1;
         return;
      end
      code = 32'(key_bytes[values_out / 4][2 * (values_out % 4) +: CODE_W]);
      consumed++;
      if (byte_pos < code) begin
         partial |= VALUE_W'(b) << (BYTE_W * byte_pos);
         byte_pos++;
         return;
      end
      delta = partial | (VALUE_W'(b) << (BYTE_W * byte_pos));
      sum += delta;
      values_out++;
      byte_pos = 0;
      partial = '0;
      beat.value = sum;
      if (values_out >= n_eff) begin
         beat.last  = 1'b1;
         beat.bytes = TOTAL_W'(consumed);
         restart_buffer();
      end else begin
         beat.last  = 1'b0;
         beat.bytes = '0;
      end
      pending_sums.push_back(beat);
   endtask

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [BYTE_W-1:0] rand_data_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_in_byte);
            bytes_taken++;
         end
         if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
         if (req_valid && req_stall) begin
            // hold the stalled beat
         end else if (src_gap > 0) begin
            src_gap--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0) begin
            req_valid   <= 1'b1;
            req_in_byte <= byte_queue.pop_front();
            src_gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               $error("unexpected result beat: decoded_value %h", rsp_decoded_value);
               errors++;
            end else begin
               want = pending_sums.pop_front();
               values_checked++;
               if (rsp_last_value) buffers_done++;
               if (rsp_decoded_value !== want.value) begin
                  $error("decoded_value: expected %h, got %h", want.value, rsp_decoded_value);
                  errors++;
               end
               if (rsp_last_value !== want.last) begin
                  $error("last_value: expected %0d, got %0d", want.last, rsp_last_value);
                  errors++;
               end
               if (rsp_bytes_used !== want.bytes) begin
                  $error("bytes_used: expected %0d, got %0d", want.bytes, rsp_bytes_used);
                  errors++;
               end
            end
         end
         if (holds_served != holds_asked && rsp_valid) begin
            holds_served++;
            stall_left = LONG_HOLD;
         end
         if ($urandom_range(0, 63) == 0) rsp_steady = !rsp_steady;
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!rsp_steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_stream_vbyte_delta_decoder: done, errors");
         $finish;
      end
   end

   task automatic offer_byte(input logic [BYTE_W-1:0] b);
      byte_queue.push_back(b);
      bytes_pushed++;
   endtask

   task automatic wait_idle();
      while (bytes_taken != bytes_pushed || pending_sums.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_VALUE_COUNT) cfg_count = data[COUNT_W-1:0];
      else cfg_start = data;
      restart_buffer();
   endtask

   // key_fill < 0 draws random length codes; cut < 0 sends the whole buffer
   task automatic send_buffer(input int n, input int key_fill, input int cut,
                              input int pause_at, output int sent);
      logic [BYTE_W-1:0] image [$];
      logic [BYTE_W-1:0] keys [$];
      logic [BYTE_W-1:0] kb;
      int                len;
      sent = 0;
      for (int k = 0; k < (n + 3) / 4; k++) begin
         kb = (key_fill < 0) ? BYTE_W'($urandom_range(0, 255)) : key_fill[BYTE_W-1:0];
         image.push_back(kb);
         keys.push_back(kb);
      end
      for (int i = 0; i < n; i++) begin
         len = keys[i / 4][2 * (i % 4) +: CODE_W] + 1;
         repeat (len) image.push_back(rand_data_byte());
      end
      for (int j = 0; j < image.size(); j++) begin
         if (cut >= 0 && j >= cut) break;
         if (j == pause_at) wait_idle();
         offer_byte(image[j]);
         sent++;
      end
   endtask

   initial begin
      int r;
      int n;
      int cut;
      int sent;
      int random_bytes;
      int cur_count;
      bit rearm_due;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_VALUE_COUNT;
      csr_wdata = '0;
      foreach (key_bytes[k]) key_bytes[k] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero count out of reset: drop every byte
      offer_byte(8'h00); offer_byte(8'hFF); offer_byte(8'h5A);

      // one value of each length, sum wraps past the top
      write_csr(CSR_START_VALUE, 32'hFFFF_FFFF);
      write_csr(CSR_VALUE_COUNT, 4);
      offer_byte(8'hE4);
      offer_byte(8'hFF);
      offer_byte(8'h00); offer_byte(8'h80);
      offer_byte(8'h01); offer_byte(8'h02); offer_byte(8'h03);
      offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'hFF);

      // single value, widest delta from zero
      write_csr(CSR_START_VALUE, 32'h0);
      write_csr(CSR_VALUE_COUNT, 1);
      offer_byte(8'h03);
      offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'hFF); offer_byte(8'hFF);

      // partly used last control byte
      write_csr(CSR_START_VALUE, 32'h7FFF_FFFF);
      write_csr(CSR_VALUE_COUNT, 5);
      offer_byte(8'h00); offer_byte(8'hFC);
      offer_byte(8'h01); offer_byte(8'h80); offer_byte(8'h7F);
      offer_byte(8'hFE); offer_byte(8'hFF);

      // count above the maximum saturates: long output hold, one sender pause
      write_csr(CSR_VALUE_COUNT, 32'h7FF);
      write_csr(CSR_START_VALUE, $urandom);
      holds_asked++;
      send_buffer(MAX_VALUES, 8'h00, -1, 700, sent);

      random_bytes = 0;
      cur_count = 0;
      rearm_due = 1'b0;
      while (random_bytes < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            write_csr(CSR_VALUE_COUNT, 0);
            cur_count = 0;
            repeat ($urandom_range(1, 6)) offer_byte(BYTE_W'($urandom_range(0, 255)));
         end else begin
            if (cur_count == 0 || rearm_due || $urandom_range(0, 2) == 0) begin
               r = $urandom_range(0, 9);
               if (r < 6) n = $urandom_range(1, 8);
               else if (r < 9) n = $urandom_range(9, 40);
               else n = $urandom_range(41, 64);
               write_csr(CSR_VALUE_COUNT, n);
               cur_count = n;
            end
            if ($urandom_range(0, 3) == 0) begin
               r = $urandom_range(0, 3);
               write_csr(CSR_START_VALUE,
                         (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom);
            end
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : -1;
            send_buffer(cur_count, -1, cut, -1, sent);
            random_bytes += sent;
            rearm_due = (cut >= 0);
         end
      end

      wait_idle();
      $display("fed %0d bytes, checked %0d values over %0d finished buffers",
               bytes_taken, values_checked, buffers_done);
      if (errors == 0) begin
         $display("tb_stream_vbyte_delta_decoder: done, clean");
      end else begin
         $display("tb_stream_vbyte_delta_decoder: done, errors");
      end
      $finish;
   end

endmodule
